// File: hdl/psd_pkg.sv
// Shared types and constants for the point-to-segment squared distance pipeline.
package psd_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int COORD_W = 16;
  localparam int NEAR_W = COORD_W + 1;
  localparam int PROD_W = 2 * COORD_W;

  typedef enum logic [1:0] {
    SEL_START  = 2'd0,
    SEL_END    = 2'd1,
    SEL_INTERP = 2'd2
  } sel_t;

  typedef struct packed {
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } pts_t;

  typedef struct packed {
    pts_t                     pts;
    logic [COORD_W-1:0]       abx;
    logic [COORD_W-1:0]       aby;
    logic [PROD_W-1:0]        num;
    logic [PROD_W-1:0]        den;
    logic [FRACTION_BITS-1:0] q;
    sel_t                     sel;
  } div_t;

endpackage

// File: hdl/psd_front.sv
// Front stages: endpoint differences, products, dot and length sums, and clamp selection.
module psd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  input  psd_pkg::pts_t      pts_in,
  output logic               valid_out,
  output psd_pkg::div_t      div_out
);

  logic                             v1_r, v2_r, v3_r, v4_r;
  psd_pkg::pts_t                    pts1_r, pts2_r, pts3_r;
  logic [psd_pkg::COORD_W-1:0]      abx1_r, aby1_r, apx1_r, apy1_r;
  logic [psd_pkg::COORD_W-1:0]      abx2_r, aby2_r, abx3_r, aby3_r;
  logic signed [psd_pkg::PROD_W-1:0] lxx_r, lyy_r, dxx_r, dyy_r;
  logic [psd_pkg::PROD_W-1:0]       len2_r, dot_r;
  logic [psd_pkg::PROD_W-1:0]       len2_nxt, dot_nxt;
  psd_pkg::sel_t                    sel_nxt;
  psd_pkg::div_t                    div_r;

  assign len2_nxt = psd_pkg::PROD_W'(lxx_r + lyy_r);
  assign dot_nxt  = psd_pkg::PROD_W'(dxx_r + dyy_r);

  always_comb begin
    if ($signed(len2_r) <= 0) begin
      sel_nxt = psd_pkg::SEL_START;
    end else if ($signed(dot_r) <= 0) begin
      sel_nxt = psd_pkg::SEL_START;
    end else if ($signed(dot_r) >= $signed(len2_r)) begin
      sel_nxt = psd_pkg::SEL_END;
    end else begin
      sel_nxt = psd_pkg::SEL_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= valid_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pts1_r <= pts_in;
    abx1_r <= pts_in.bx - pts_in.ax;
    aby1_r <= pts_in.by - pts_in.ay;
    apx1_r <= pts_in.px - pts_in.ax;
    apy1_r <= pts_in.py - pts_in.ay;

    pts2_r <= pts1_r;
    abx2_r <= abx1_r;
    aby2_r <= aby1_r;
    lxx_r  <= $signed(abx1_r) * $signed(abx1_r);
    lyy_r  <= $signed(aby1_r) * $signed(aby1_r);
    dxx_r  <= $signed(apx1_r) * $signed(abx1_r);
    dyy_r  <= $signed(apy1_r) * $signed(aby1_r);

    pts3_r <= pts2_r;
    abx3_r <= abx2_r;
    aby3_r <= aby2_r;
    len2_r <= len2_nxt;
    dot_r  <= dot_nxt;

    div_r.pts <= pts3_r;
    div_r.abx <= abx3_r;
    div_r.aby <= aby3_r;
    div_r.num <= dot_r;
    div_r.den <= len2_r;
    div_r.q   <= '0;
    div_r.sel <= sel_nxt;
  end

  assign valid_out = v4_r;
  assign div_out   = div_r;

endmodule

// File: hdl/psd_div_step.sv
// One registered step of the restoring division that forms the projection fraction.
module psd_div_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  input  psd_pkg::div_t div_in,
  output logic          valid_out,
  output psd_pkg::div_t div_out
);

  logic [psd_pkg::PROD_W-1:0] num2;
  logic                       ge;
  psd_pkg::div_t              div_nxt;
  psd_pkg::div_t              div_r;
  logic                       valid_r;

  always_comb begin
    num2        = {div_in.num[psd_pkg::PROD_W-2:0], 1'b0};
    ge          = (num2 >= div_in.den);
    div_nxt     = div_in;
    div_nxt.num = ge ? num2 - div_in.den : num2;
    div_nxt.q   = (div_in.q << 1) | psd_pkg::FRACTION_BITS'(ge);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign valid_out = valid_r;
  assign div_out   = div_r;

endmodule

// File: hdl/psd_back.sv
// Back stages: interpolation of the nearest point and the squared distance to it.
module psd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_in,
  input  psd_pkg::div_t                    div_in,
  output logic                             valid_out,
  output logic signed [psd_pkg::PROD_W-1:0] dist_sq,
  output logic signed [psd_pkg::NEAR_W-1:0] near_x,
  output logic signed [psd_pkg::NEAR_W-1:0] near_y
);

  logic                              v1_r, v2_r, v3_r, v4_r, v5_r;
  psd_pkg::pts_t                     pts1_r;
  psd_pkg::sel_t                     sel1_r;
  logic signed [psd_pkg::PROD_W-1:0] mx_r, my_r;
  logic signed [psd_pkg::PROD_W-1:0] offx, offy;
  logic [psd_pkg::NEAR_W-1:0]        cx_nxt, cy_nxt;
  logic [psd_pkg::NEAR_W-1:0]        cx2_r, cy2_r, cx3_r, cy3_r, cx4_r, cy4_r;
  logic [psd_pkg::NEAR_W-1:0]        cx5_r, cy5_r;
  logic [psd_pkg::COORD_W-1:0]       px2_r, py2_r;
  logic [psd_pkg::COORD_W-1:0]       dx3_r, dy3_r;
  logic signed [psd_pkg::PROD_W-1:0] sx_r, sy_r;
  logic [psd_pkg::PROD_W-1:0]        dist_r;

  always_comb begin
    offx = mx_r >>> psd_pkg::FRACTION_BITS;
    offy = my_r >>> psd_pkg::FRACTION_BITS;
    case (sel1_r)
      psd_pkg::SEL_END: begin
        cx_nxt = {pts1_r.bx[psd_pkg::COORD_W-1], pts1_r.bx};
        cy_nxt = {pts1_r.by[psd_pkg::COORD_W-1], pts1_r.by};
      end
      psd_pkg::SEL_INTERP: begin
        cx_nxt = {pts1_r.ax[psd_pkg::COORD_W-1], pts1_r.ax} + offx[psd_pkg::NEAR_W-1:0];
        cy_nxt = {pts1_r.ay[psd_pkg::COORD_W-1], pts1_r.ay} + offy[psd_pkg::NEAR_W-1:0];
      end
      default: begin
        cx_nxt = {pts1_r.ax[psd_pkg::COORD_W-1], pts1_r.ax};
        cy_nxt = {pts1_r.ay[psd_pkg::COORD_W-1], pts1_r.ay};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= valid_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    pts1_r <= div_in.pts;
    sel1_r <= div_in.sel;
    mx_r   <= $signed(div_in.abx) * $signed({1'b0, div_in.q});
    my_r   <= $signed(div_in.aby) * $signed({1'b0, div_in.q});

    cx2_r  <= cx_nxt;
    cy2_r  <= cy_nxt;
    px2_r  <= pts1_r.px;
    py2_r  <= pts1_r.py;

    cx3_r  <= cx2_r;
    cy3_r  <= cy2_r;
    dx3_r  <= px2_r - cx2_r[psd_pkg::COORD_W-1:0];
    dy3_r  <= py2_r - cy2_r[psd_pkg::COORD_W-1:0];

    cx4_r  <= cx3_r;
    cy4_r  <= cy3_r;
    sx_r   <= $signed(dx3_r) * $signed(dx3_r);
    sy_r   <= $signed(dy3_r) * $signed(dy3_r);

    cx5_r  <= cx4_r;
    cy5_r  <= cy4_r;
    dist_r <= psd_pkg::PROD_W'(sx_r + sy_r);
  end

  assign valid_out = v5_r;
  assign dist_sq   = $signed(dist_r);
  assign near_x    = $signed(cx5_r);
  assign near_y    = $signed(cy5_r);

endmodule

// File: hdl/point_segment_distance_squared_top.sv
// Top level of the point-to-segment squared distance pipeline.
//
// An item is a segment (start and end point) and a query point, all signed
// 16-bit. It is taken at a rising edge with start high and busy low; busy is
// always low, so one item may be taken in every cycle.
// Each item gives one result: the squared distance as a wrapping 32-bit sum,
// and the nearest point of the segment as signed 17-bit coordinates. The
// result is shown for exactly one cycle with out_valid high.
// Four front stages form the dot product and squared length, one stage per
// quotient bit runs the restoring division, and five back stages interpolate
// and form the distance. Throughput is one item per cycle.
// Results leave in the order in which items were taken.
// Reset clears every valid bit, so no result appears from items in flight.
// The receiver cannot stall the block, and no stall point exists inside it.
module point_segment_distance_squared_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_end_y,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_point_y,
  output logic                                out_valid,
  output logic signed [psd_pkg::PROD_W-1:0]   out_dist_sq,
  output logic signed [psd_pkg::NEAR_W-1:0]   out_near_x,
  output logic signed [psd_pkg::NEAR_W-1:0]   out_near_y
);

  psd_pkg::pts_t pts_in;
  logic          accept;
  psd_pkg::div_t stage_d [psd_pkg::FRACTION_BITS+1];
  logic          stage_v [psd_pkg::FRACTION_BITS+1];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign pts_in.ax = in_start_x;
  assign pts_in.ay = in_start_y;
  assign pts_in.bx = in_end_x;
  assign pts_in.by = in_end_y;
  assign pts_in.px = in_point_x;
  assign pts_in.py = in_point_y;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (accept),
    .pts_in    (pts_in),
    .valid_out (stage_v[0]),
    .div_out   (stage_d[0])
  );

  for (genvar i = 0; i < psd_pkg::FRACTION_BITS; i++) begin : g_div
    psd_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (stage_v[i]),
      .div_in    (stage_d[i]),
      .valid_out (stage_v[i+1]),
      .div_out   (stage_d[i+1])
    );
  end

  psd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (stage_v[psd_pkg::FRACTION_BITS]),
    .div_in    (stage_d[psd_pkg::FRACTION_BITS]),
    .valid_out (out_valid),
    .dist_sq   (out_dist_sq),
    .near_x    (out_near_x),
    .near_y    (out_near_y)
  );

endmodule

// File: tb/psd_checker.sv
// Checker that predicts and compares every result of the point-to-segment distance block.
module psd_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_end_y,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [psd_pkg::COORD_W-1:0]  in_point_y,
  input  logic                                out_valid,
  input  logic signed [psd_pkg::PROD_W-1:0]   out_dist_sq,
  input  logic signed [psd_pkg::NEAR_W-1:0]   out_near_x,
  input  logic signed [psd_pkg::NEAR_W-1:0]   out_near_y,
  output int                                  fail_count,
  output int                                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [psd_pkg::PROD_W-1:0] dist_sq;
    logic [psd_pkg::NEAR_W-1:0] near_x;
    logic [psd_pkg::NEAR_W-1:0] near_y;
  } nearest_t;

  nearest_t pending_results[$];
  int       mismatch_total = 0;

  function automatic logic signed [31:0] mul16(input logic [31:0] a, input logic [31:0] b);
    logic signed [31:0] ea;
    logic signed [31:0] eb;
    ea = $signed(a[15:0]);
    eb = $signed(b[15:0]);
    return ea * eb;
  endfunction

  function automatic logic [31:0] restoring_quotient(input logic [31:0] num,
                                                     input logic [31:0] den);
    logic [31:0] rem;
    logic [31:0] q;
    rem = num;
    q = '0;
    for (int i = 0; i < psd_pkg::FRACTION_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q + 1;
      end
    end
    return q;
  endfunction

  function automatic nearest_t nearest_point_distance(input psd_pkg::pts_t item);
    logic signed [31:0] sax, say, sbx, sby, spx, spy;
    logic [31:0]        abx, aby, apx, apy, frac, cx, cy, dx, dy;
    logic signed [31:0] seg_len2, dot;
    nearest_t           r;
    sax = $signed(item.ax);
    say = $signed(item.ay);
    sbx = $signed(item.bx);
    sby = $signed(item.by);
    spx = $signed(item.px);
    spy = $signed(item.py);
    abx = sbx - sax;
    aby = sby - say;
    apx = spx - sax;
    apy = spy - say;
    seg_len2 = mul16(abx, abx) + mul16(aby, aby);
    cx = sax;
    cy = say;
    if (seg_len2 > 0) begin
      dot = mul16(apx, abx) + mul16(apy, aby);
      if (dot > 0) begin
        if (dot >= seg_len2) begin
          cx = sbx;
          cy = sby;
        end else begin
          frac = restoring_quotient(dot, seg_len2);
          cx = sax + (mul16(abx, frac) >>> psd_pkg::FRACTION_BITS);
          cy = say + (mul16(aby, frac) >>> psd_pkg::FRACTION_BITS);
        end
      end
    end
    dx = spx - cx;
    dy = spy - cy;
    r.dist_sq = mul16(dx, dx) + mul16(dy, dy);
    r.near_x = cx[psd_pkg::NEAR_W-1:0];
    r.near_y = cy[psd_pkg::NEAR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %08h, expected %08h", $time, what, got, want);
    mismatch_total++;
  endtask

  always @(posedge clk) begin
    nearest_t       want;
    psd_pkg::pts_t  item;
    if (!rst_n) begin
      pending_results.delete();
    end else begin
      if (start === 1'b1 && busy === 1'b0) begin
        item.ax = in_start_x;
        item.ay = in_start_y;
        item.bx = in_end_x;
        item.by = in_end_y;
        item.px = in_point_x;
        item.py = in_point_y;
        pending_results.push_back(nearest_point_distance(item));
      end
      if (out_valid !== 1'b0) begin
        if (out_valid !== 1'b1) begin
          report_mismatch("out_valid", out_valid, 1);
        end else if (pending_results.size() == 0) begin
          report_mismatch("unexpected result dist_sq", out_dist_sq, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_dist_sq !== want.dist_sq)
            report_mismatch("dist_sq", out_dist_sq, want.dist_sq);
          if (out_near_x !== want.near_x)
            report_mismatch("near_x", out_near_x, want.near_x);
          if (out_near_y !== want.near_y)
            report_mismatch("near_y", out_near_y, want.near_y);
        end
      end
    end
    pending_count <= pending_results.size();
    fail_count <= mismatch_total;
  end

endmodule

// File: tb/testbench.sv
// Top of the testbench: clock, reset, item stimulus and the final verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 24;

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic signed [psd_pkg::COORD_W-1:0]  in_start_x;
  logic signed [psd_pkg::COORD_W-1:0]  in_start_y;
  logic signed [psd_pkg::COORD_W-1:0]  in_end_x;
  logic signed [psd_pkg::COORD_W-1:0]  in_end_y;
  logic signed [psd_pkg::COORD_W-1:0]  in_point_x;
  logic signed [psd_pkg::COORD_W-1:0]  in_point_y;
  logic                                out_valid;
  logic signed [psd_pkg::PROD_W-1:0]   out_dist_sq;
  logic signed [psd_pkg::NEAR_W-1:0]   out_near_x;
  logic signed [psd_pkg::NEAR_W-1:0]   out_near_y;
  int                                  fail_count;
  int                                  pending_count;

  point_segment_distance_squared_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_start_x  (in_start_x),
    .in_start_y  (in_start_y),
    .in_end_x    (in_end_x),
    .in_end_y    (in_end_y),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .out_valid   (out_valid),
    .out_dist_sq (out_dist_sq),
    .out_near_x  (out_near_x),
    .out_near_y  (out_near_y)
  );

  psd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .out_valid     (out_valid),
    .out_dist_sq   (out_dist_sq),
    .out_near_x    (out_near_x),
    .out_near_y    (out_near_y),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic psd_pkg::pts_t make_segment(input int ax, input int ay, input int bx,
                                                 input int by, input int px, input int py);
    psd_pkg::pts_t item;
    item.ax = ax[15:0];
    item.ay = ay[15:0];
    item.bx = bx[15:0];
    item.by = by[15:0];
    item.px = px[15:0];
    item.py = py[15:0];
    return item;
  endfunction

  function automatic int signed_offset(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic psd_pkg::pts_t make_random_item();
    psd_pkg::pts_t item;
    int            kind;
    int            span;
    int            ax, ay;
    kind = $urandom_range(0, 9);
    item = make_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (kind < 6) begin
      case ($urandom_range(0, 3))
        0: span = 15;
        1: span = 255;
        2: span = 4095;
        default: span = 16383;
      endcase
      ax = $signed(item.ax);
      ay = $signed(item.ay);
      item.bx = 16'(ax + signed_offset(span));
      item.by = 16'(ay + signed_offset(span));
      item.px = 16'(ax + signed_offset(2 * span));
      item.py = 16'(ay + signed_offset(2 * span));
    end else if (kind == 6) begin
      item.bx = item.ax;
      item.by = item.ay;
    end else if (kind == 7) begin
      if ($urandom_range(0, 1) == 1) begin
        item.px = item.bx;
        item.py = item.by;
      end else begin
        item.px = item.ax;
        item.py = item.ay;
      end
    end else if (kind == 8) begin
      item.ax = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      item.by = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      item.px = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    end
    return item;
  endfunction

  task automatic send_item(input psd_pkg::pts_t item);
    start <= 1'b1;
    in_start_x <= item.ax;
    in_start_y <= item.ay;
    in_end_x <= item.bx;
    in_end_y <= item.by;
    in_point_x <= item.px;
    in_point_y <= item.py;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    psd_pkg::pts_t directed[$];
    int            sent;
    int            burst;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x <= '0;
    in_end_y <= '0;
    in_point_x <= '0;
    in_point_y <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_segment(0, 0, 0, 0, 0, 0));
    directed.push_back(make_segment(-32768, -32768, -32768, -32768, 32767, 32767));
    directed.push_back(make_segment(0, 0, 100, 0, -50, 10));
    directed.push_back(make_segment(0, 0, 100, 0, 0, 50));
    directed.push_back(make_segment(0, 0, 100, 0, 200, 5));
    directed.push_back(make_segment(0, 0, 100, 0, 100, 30));
    directed.push_back(make_segment(0, 0, 100, 0, 50, 20));
    directed.push_back(make_segment(0, 0, 100, 40, 37, -13));
    directed.push_back(make_segment(-32768, 0, 32767, 0, 0, 0));
    directed.push_back(make_segment(-32768, -32768, 32767, 32767, 0, 0));
    directed.push_back(make_segment(32767, 32767, -32768, -32768, -32768, 32767));
    directed.push_back(make_segment(0, 0, -32768, -32768, -100, -200));
    directed.push_back(make_segment(0, 0, 32767, 32767, 16000, 16100));
    directed.push_back(make_segment(0, 0, -32768, 0, -1000, 5));
    directed.push_back(make_segment(1000, -2000, -3000, 4000, 0, 0));
    directed.push_back(make_segment(-100, -100, 100, 100, -32768, 32767));
    directed.push_back(make_segment(0, 0, 10000, 0, 1, 0));
    directed.push_back(make_segment(0, 0, 10000, 0, 9999, 0));
    directed.push_back(make_segment(32767, -32768, 32767, -32768, -32768, 32767));
    directed.push_back(make_segment(-1, -1, 1, 1, 32767, -32768));
    foreach (directed[i]) begin
      send_item(directed[i]);
      if (i % 5 == 4) idle_cycles(i / 5 + 1);
    end
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 48);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_item(make_random_item());
        sent++;
        if (sent == RANDOM_ITEMS / 2) wait_drained();
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 24));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
